/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the two-wire transceiver.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/twhbt_pkg.sv */
// Package for the two-wire half-bit transceiver: word sizes, bit-state codes
// and the types built on them. Depends on nothing.
package twhbt_pkg;

    // Length of a received word; the transmit word is fixed at 32 bits.
    localparam int WORD_BITS    = 32;
    localparam int TX_WORD_BITS = 32;
    localparam int RX_WORD_BITS = 32;
    localparam int TXI_BITS     = $clog2(TX_WORD_BITS);

    // Bit-state code space: wait, direction, receive range, transmit range.
    localparam int RX_FIRST_I  = 16;
    localparam int TX_LAST_I   = RX_FIRST_I + 2 * WORD_BITS - 1;
    localparam int STATE_BITS  = $clog2(TX_LAST_I + 1);
    localparam int EXT_BITS    = (WORD_BITS > RX_WORD_BITS) ? WORD_BITS : RX_WORD_BITS;

    typedef logic [STATE_BITS-1:0]   t_bit_state;
    typedef logic [WORD_BITS-1:0]    t_rx_shift;
    typedef logic [EXT_BITS-1:0]     t_ext_word;
    typedef logic [RX_WORD_BITS-1:0] t_rx_word;
    typedef logic [TX_WORD_BITS-1:0] t_tx_word;

    localparam t_bit_state ST_WAIT  = t_bit_state'(0);
    localparam t_bit_state ST_DIR   = t_bit_state'(1);
    localparam t_bit_state RX_FIRST = t_bit_state'(RX_FIRST_I);
    localparam t_bit_state RX_LAST  = t_bit_state'(RX_FIRST_I + WORD_BITS - 1);
    localparam t_bit_state TX_FIRST = t_bit_state'(RX_FIRST_I + WORD_BITS);
    localparam t_bit_state TX_LAST  = t_bit_state'(TX_LAST_I);

endpackage

/* rtl/core/twhbt_in_if.sv */
// Input channel of the transceiver: one sampled clock edge per transfer.
// Depends on twhbt_pkg.
interface twhbt_in_if
    import twhbt_pkg::*;
();
    logic     valid;
    logic     ready;
    logic     line_level;
    t_tx_word tx_word;

    modport source (output valid, output line_level, output tx_word, input ready);
    modport sink   (input valid, input line_level, input tx_word, output ready);
endinterface

/* rtl/core/twhbt_out_if.sv */
// Output channel of the transceiver: line drive and received word per transfer.
// Depends on twhbt_pkg.
interface twhbt_out_if
    import twhbt_pkg::*;
();
    logic     valid;
    logic     ready;
    logic     drive_low;
    logic     rx_valid;
    t_rx_word rx_word;

    modport source (output valid, output drive_low, output rx_valid, output rx_word,
                    input ready);
    modport sink   (input valid, input drive_low, input rx_valid, input rx_word,
                    output ready);
endinterface

/* rtl/core/two_wire_half_bit_transceiver.sv */
// The result of an input transfer is offered in the cycle after it is taken.
// Throughput: one transfer per cycle; input is taken whenever the result register
// is empty or is being emptied in the same cycle, so a stalled output stalls input.
// The line state advances in the accepting cycle, so the next edge follows at once.
// Reset (synchronous, active low) returns to waiting for sync with the line released.
// Depends on twhbt_pkg, twhbt_in_if, twhbt_out_if and assert_macros.svh.
`include "assert_macros.svh"

module two_wire_half_bit_transceiver
    import twhbt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    twhbt_in_if.sink          i_in,
    twhbt_out_if.source       o_out
);

    // Protocol state.
    t_bit_state r_bit_state, n_bit_state;
    logic       r_odd_phase, n_odd_phase;
    logic       r_prev_level, n_prev_level;
    logic       r_prev_prev_level, n_prev_prev_level;
    t_rx_shift  r_rx_shift, n_rx_shift;
    logic       r_line_drive, n_line_drive;

    // Result register.
    logic       r_out_valid;
    logic       r_drive_low;
    logic       r_rx_valid;
    t_rx_word   r_rx_word;

    logic       w_accept;
    logic       w_line_reset;
    logic       w_one;
    logic       w_zero;
    logic       w_rx_active;
    logic       w_tx_active;
    t_bit_state w_tx_idx;
    logic       w_tx_bit;
    logic       w_got;
    t_ext_word  w_rx_ext;

    // The input is taken whenever the result slot is free or frees this cycle.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // Half-bit events decoded from the current and previous line samples.
    assign w_line_reset = !i_in.line_level && !r_prev_level && !r_prev_prev_level;
    assign w_one        = i_in.line_level && !r_prev_level;
    assign w_zero       = !i_in.line_level && r_prev_level;

    assign w_rx_active = (r_bit_state >= RX_FIRST) && (r_bit_state <= RX_LAST);
    assign w_tx_active = (r_bit_state >= TX_FIRST) && (r_bit_state <= TX_LAST);

    // Bit of the transmit word for this state; positions past the word send zero.
    assign w_tx_idx = t_bit_state'(r_bit_state - TX_FIRST);
    assign w_tx_bit = (w_tx_idx < t_bit_state'(TX_WORD_BITS))
                    ? i_in.tx_word[w_tx_idx[TXI_BITS-1:0]] : 1'b0;

    // Next protocol state for one clock edge.
    always_comb begin
        n_bit_state       = r_bit_state;
        n_odd_phase       = r_odd_phase;
        n_rx_shift        = r_rx_shift;
        n_line_drive      = r_line_drive;
        n_prev_prev_level = r_prev_level;
        n_prev_level      = i_in.line_level;
        w_got             = 1'b0;

        if (w_line_reset) begin
            // Three low samples: back to sync, line released, next edge is odd.
            n_bit_state  = ST_WAIT;
            n_line_drive = 1'b0;
            n_odd_phase  = 1'b1;
        end else if (r_odd_phase) begin
            n_odd_phase = 1'b0;
            if (r_bit_state == ST_WAIT) begin
                n_bit_state = w_one ? ST_DIR : ST_WAIT;
            end else if (r_bit_state == ST_DIR) begin
                if (w_one) begin
                    n_rx_shift  = '0;
                    n_bit_state = RX_FIRST;
                end else if (w_zero) begin
                    n_bit_state = TX_FIRST;
                end else begin
                    n_bit_state = ST_WAIT;
                end
            end else if (w_rx_active) begin
                // Receive shifts in MSB first.
                n_rx_shift = {r_rx_shift[WORD_BITS-2:0], w_one};
                if (r_bit_state == RX_LAST) begin
                    w_got       = 1'b1;
                    n_bit_state = ST_WAIT;
                end else begin
                    n_bit_state = t_bit_state'(r_bit_state + 1'b1);
                end
            end else if (w_tx_active) begin
                // Odd edge carries the true bit: a zero pulls the line low.
                n_line_drive = !w_tx_bit;
                n_bit_state  = (r_bit_state == TX_LAST) ? ST_WAIT
                             : t_bit_state'(r_bit_state + 1'b1);
            end
        end else begin
            // Even edge carries the inverted bit.
            if (w_tx_active) begin
                n_line_drive = w_tx_bit;
            end
            n_odd_phase = 1'b1;
        end
    end

    assign w_rx_ext = t_ext_word'(n_rx_shift);

    // Protocol state advances once per accepted transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_state       <= ST_WAIT;
            r_odd_phase       <= 1'b0;
            r_prev_level      <= 1'b1;
            r_prev_prev_level <= 1'b1;
            r_rx_shift        <= '0;
            r_line_drive      <= 1'b0;
        end else if (w_accept) begin
            r_bit_state       <= n_bit_state;
            r_odd_phase       <= n_odd_phase;
            r_prev_level      <= n_prev_level;
            r_prev_prev_level <= n_prev_prev_level;
            r_rx_shift        <= n_rx_shift;
            r_line_drive      <= n_line_drive;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload is loaded with each accepted transfer.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_drive_low <= n_line_drive;
            r_rx_valid  <= w_got;
            r_rx_word   <= w_got ? w_rx_ext[RX_WORD_BITS-1:0] : '0;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.drive_low = r_drive_low;
    assign o_out.rx_valid  = r_rx_valid;
    assign o_out.rx_word   = r_rx_word;

    // Protocol state only moves on an accepted transfer.
    `ASSERT_NEXT(a_state_holds, !w_accept,
                 $stable(r_bit_state) && $stable(r_line_drive),
                 "state moved without a transfer")
    // A line reset releases the line and waits for sync on an odd edge.
    `ASSERT_NEXT(a_line_reset, w_accept && w_line_reset,
                 (r_bit_state == ST_WAIT) && r_odd_phase && !r_line_drive,
                 "line reset not taken")
    // A finished word returns the machine to waiting for sync.
    `ASSERT_NEXT(a_rx_done, w_accept && w_got,
                 (r_bit_state == ST_WAIT) && r_rx_valid,
                 "word end not handled")
    // No received word is shown without its flag.
    `ASSERT_SAME(a_rx_word_zero, r_out_valid && !r_rx_valid, r_rx_word == '0,
                 "stray received word")

endmodule
